// ===== sv/pcsc_pkg.sv =====
package pcsc_pkg;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 104;
  localparam int unsigned OUT_TUSER_W = 3;
  localparam int unsigned RES_FIFO_DEPTH = 4;

  // result event codes
  localparam logic [2:0] EV_CHUNK    = 3'd0;
  localparam logic [2:0] EV_BAD_SIG  = 3'd1;
  localparam logic [2:0] EV_NOT_IHDR = 3'd2;
  localparam logic [2:0] EV_UNSUPP   = 3'd3;
  localparam logic [2:0] EV_IEND     = 3'd4;
  localparam logic [2:0] EV_NO_IEND  = 3'd5;
  localparam logic [2:0] EV_IHDR_OK  = 3'd6;

  // chunk kinds
  localparam logic [1:0] KIND_IHDR  = 2'd0;
  localparam logic [1:0] KIND_IDAT  = 2'd1;
  localparam logic [1:0] KIND_IEND  = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // parse phases
  localparam logic [2:0] PH_SIG  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_TYPE = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;

  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  localparam logic [31:0] IHDR_MIN_LEN = 32'd13;
  localparam logic [7:0]  BIT_DEPTH_8  = 8'd8;
  localparam logic [7:0]  COLOUR_RGBA  = 8'd6;

  typedef struct packed {
    logic [2:0]  ev;
    logic [1:0]  kind;
    logic [31:0] len;
    logic [31:0] width;
    logic [31:0] height;
    logic        success;
    logic        last;
  } res_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'd137;
      3'd1:    b = 8'd80;
      3'd2:    b = 8'd78;
      3'd3:    b = 8'd71;
      3'd4:    b = 8'd13;
      3'd5:    b = 8'd10;
      3'd6:    b = 8'd26;
      default: b = 8'd10;
    endcase
    return b;
  endfunction

  function automatic logic [1:0] kind_of(input logic [31:0] t);
    logic [1:0] k;
    if (t == TYPE_IHDR) k = KIND_IHDR;
    else if (t == TYPE_IDAT) k = KIND_IDAT;
    else if (t == TYPE_IEND) k = KIND_IEND;
    else k = KIND_OTHER;
    return k;
  endfunction

  function automatic logic is_success(input logic [2:0] ev);
    return (ev == EV_CHUNK) || (ev == EV_IEND) || (ev == EV_NO_IEND) || (ev == EV_IHDR_OK);
  endfunction

endpackage

// ===== sv/pcsc_parser.sv =====
module pcsc_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat_vld,
  input  logic [7:0]        beat_byte,
  input  logic              beat_fin,
  output logic [1:0]        res_cnt,
  output pcsc_pkg::res_t    res0,
  output pcsc_pkg::res_t    res1
);
  import pcsc_pkg::*;

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] length_r, length_nxt;
  logic [31:0] type_r, type_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic        first_r, first_nxt;
  logic        done_r, done_nxt;

  logic        a_vld, f_vld, bad;
  logic [2:0]  a_ev, f_ev;
  logic [1:0]  a_kind, tkind;
  logic [31:0] a_len, f_len, cnt_inc;
  res_t        ra, rf;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    length_nxt = length_r;
    type_nxt   = type_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    first_nxt  = first_r;
    done_nxt   = done_r;
    a_vld  = 1'b0;
    a_ev   = EV_CHUNK;
    a_kind = KIND_IHDR;
    a_len  = '0;
    f_vld  = 1'b0;
    f_ev   = EV_NO_IEND;
    f_len  = '0;
    bad    = 1'b0;
    cnt_inc = cnt_r + 32'd1;
    tkind  = kind_of({type_r[23:0], beat_byte});

    if (!done_r) begin
      case (phase_r)
        PH_SIG: begin
          if (beat_byte != sig_byte(cnt_r[2:0])) begin
            a_vld    = 1'b1;
            a_ev     = EV_BAD_SIG;
            done_nxt = 1'b1;
          end else if (cnt_r[2:0] == 3'd7) begin
            phase_nxt = PH_LEN;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_LEN: begin
          length_nxt = {length_r[23:0], beat_byte};
          if (cnt_r[1:0] == 2'd3) begin
            phase_nxt = PH_TYPE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_TYPE: begin
          type_nxt = {type_r[23:0], beat_byte};
          if (cnt_r[1:0] == 2'd3) begin
            cnt_nxt = '0;
            a_kind  = tkind;
            a_len   = length_r;
            if (first_r) begin
              if (tkind != KIND_IHDR) begin
                a_vld    = 1'b1;
                a_ev     = EV_NOT_IHDR;
                done_nxt = 1'b1;
              end else if (length_r < IHDR_MIN_LEN) begin
                a_vld    = 1'b1;
                a_ev     = EV_UNSUPP;
                done_nxt = 1'b1;
              end else begin
                phase_nxt = PH_DATA;
              end
            end else if (tkind == KIND_IEND) begin
              a_vld    = 1'b1;
              a_ev     = EV_IEND;
              done_nxt = 1'b1;
            end else begin
              a_vld     = 1'b1;
              a_ev      = EV_CHUNK;
              phase_nxt = (length_r == 32'd0) ? PH_CRC : PH_DATA;
            end
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_DATA: begin
          if (first_r) begin
            // ihdr fields: width, height, then the five format bytes
            if (cnt_r < 32'd4) width_nxt = {width_r[23:0], beat_byte};
            else if (cnt_r < 32'd8) height_nxt = {height_r[23:0], beat_byte};
            else if (cnt_r == 32'd8) bad = (beat_byte != BIT_DEPTH_8);
            else if (cnt_r == 32'd9) bad = (beat_byte != COLOUR_RGBA);
            else if (cnt_r <= 32'd12) bad = (beat_byte != 8'd0);
            a_len = length_r;
            if (bad) begin
              a_vld    = 1'b1;
              a_ev     = EV_UNSUPP;
              done_nxt = 1'b1;
            end else if (cnt_r == 32'd12) begin
              a_vld     = 1'b1;
              a_ev      = EV_IHDR_OK;
              first_nxt = 1'b0;
            end
          end
          cnt_nxt = cnt_inc;
          if (!done_nxt && cnt_inc == length_r) begin
            phase_nxt = PH_CRC;
            cnt_nxt   = '0;
          end
        end
        default: begin
          if (cnt_r[1:0] == 2'd3) begin
            phase_nxt  = PH_LEN;
            cnt_nxt    = '0;
            length_nxt = '0;
            type_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      endcase
    end

    if (beat_fin && !done_nxt) begin
      f_vld = 1'b1;
      if (phase_nxt == PH_SIG) begin
        f_ev = EV_BAD_SIG;
      end else if (first_nxt && (phase_nxt == PH_LEN || phase_nxt == PH_TYPE)) begin
        f_ev = EV_NOT_IHDR;
      end else if (first_nxt) begin
        f_ev  = EV_UNSUPP;
        f_len = length_nxt;
      end else begin
        f_ev = EV_NO_IEND;
      end
    end

    ra = '{ev: a_ev, kind: a_kind, len: a_len, width: width_nxt, height: height_nxt,
           success: is_success(a_ev), last: !f_vld};
    rf = '{ev: f_ev, kind: KIND_IHDR, len: f_len, width: width_nxt, height: height_nxt,
           success: is_success(f_ev), last: 1'b1};

    res0    = a_vld ? ra : rf;
    res1    = rf;
    res_cnt = beat_vld ? ({1'b0, a_vld} + {1'b0, f_vld}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (beat_vld && beat_fin)) begin
      // the last byte of a file leaves the walker ready for the next one
      phase_r  <= PH_SIG;
      cnt_r    <= '0;
      length_r <= '0;
      type_r   <= '0;
      width_r  <= '0;
      height_r <= '0;
      first_r  <= 1'b1;
      done_r   <= 1'b0;
    end else if (beat_vld) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      length_r <= length_nxt;
      type_r   <= type_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      first_r  <= first_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule

// ===== sv/pcsc_res_fifo.sv =====
module pcsc_res_fifo #(
  parameter int unsigned Depth = pcsc_pkg::RES_FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_cnt,
  input  pcsc_pkg::res_t    push0,
  input  pcsc_pkg::res_t    push1,
  output logic              room,
  output logic              pop_vld,
  input  logic              pop_rdy,
  output pcsc_pkg::res_t    pop_res
);
  import pcsc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [CntW-1:0] count_r, count_nxt;
  logic            pop;

  assign wr_ptr_p1 = wr_ptr_r + PtrW'(1);
  assign pop       = pop_vld && pop_rdy;
  assign pop_vld   = (count_r != '0);
  assign pop_res   = mem_r[rd_ptr_r];
  // two free slots needed since a final byte may raise two results
  assign room      = (count_r <= CntW'(Depth - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PtrW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + PtrW'(pop);
    count_nxt  = count_r + CntW'(push_cnt) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_ptr_r] <= push0;
    if (push_cnt == 2'd2) mem_r[wr_ptr_p1] <= push1;
  end

endmodule

// ===== sv/png_chunk_stream_checker.sv =====
// png chunk stream checker: walks a png file given one byte per beat
// input channel in_*: in_tdata carries the file byte, in_tlast marks the last byte of the file
// output channel out_*: one beat per result; out_tuser is the event code,
//   out_tdata the chunk kind, chunk length, captured width/height and success flag,
//   out_tlast marks the last result raised by one input byte
// a result is written to the result queue when its byte is taken and offered on out_tvalid once it reaches the head
// throughput: one byte per cycle while in_tready is high; most bytes raise no result,
//   a chunk header after IHDR raises one, and only a final byte can raise two, which
//   drain through the result queue; the queue holds FifoDepth results; in_tready
//   drops while fewer than two slots are free, so a stalled receiver back-pressures
//   the byte stream and nothing is lost
// reset (rst_n low, synchronous) empties the queue and returns the walker to the
//   signature phase; the final byte of each file does the same for the walker
module png_chunk_stream_checker #(
  parameter int unsigned FifoDepth = pcsc_pkg::RES_FIFO_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pcsc_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] data_byte
  input  logic                                in_tlast,   // final_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [1:0] chunk_kind, [33:2] chunk_length, [65:34] image_width,
  // [97:66] image_height, [98] success, [103:99] zero
  output logic [pcsc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [pcsc_pkg::OUT_TUSER_W-1:0]    out_tuser,  // [2:0] event_res
  output logic                                out_tlast   // last_result
);
  import pcsc_pkg::*;

  logic       beat_vld;
  logic [1:0] res_cnt;
  res_t       res0, res1, head;

  // byte taken this edge
  assign beat_vld = in_tvalid && in_tready;

  // chunk walker: state update and result build in one pass per byte
  pcsc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_vld  (beat_vld),
    .beat_byte (in_tdata[7:0]),
    .beat_fin  (in_tlast),
    .res_cnt   (res_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  // result queue decouples the byte side from a stalled receiver
  pcsc_res_fifo #(
    .Depth (FifoDepth)
  ) u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (res_cnt),
    .push0    (res0),
    .push1    (res1),
    .room     (in_tready),
    .pop_vld  (out_tvalid),
    .pop_rdy  (out_tready),
    .pop_res  (head)
  );

  // beat packing, lowest field first
  assign out_tdata = {5'b0, head.success, head.height, head.width, head.len, head.kind};
  assign out_tuser = head.ev;
  assign out_tlast = head.last;

endmodule

// ===== sv/pcsc_checker.sv =====
module pcsc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [pcsc_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                              in_tlast,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [pcsc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [pcsc_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input logic                              out_tlast
);
  import pcsc_pkg::*;

  // queue is empty straight after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // the byte side only stalls while results are backed up
  a_stall_has_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty result queue");

  // success flag follows the event code
  a_success_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[98] == ((out_tuser == EV_CHUNK) || (out_tuser == EV_IEND) ||
                                      (out_tuser == EV_NO_IEND) || (out_tuser == EV_IHDR_OK))))
    else $error("success flag disagrees with event");

  // bad signature and missing iend carry no chunk information
  a_no_chunk_info: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == EV_BAD_SIG) || (out_tuser == EV_NO_IEND))
      |-> (out_tdata[33:0] == 34'd0))
    else $error("chunk kind or length set on a non-chunk event");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result beat changed while stalled");

endmodule

bind png_chunk_stream_checker pcsc_checker u_pcsc_checker (.*);
